// ===== design/zbsf_pkg.sv =====
// ----------------------------------------------------------------------------
// zbsf_pkg - shared types and constants for the z-buffered flat span filler
// Sequencer states, register indexes, fixed-point constants and small helpers.
// ----------------------------------------------------------------------------
package zbsf_pkg;

    // Default geometry
    localparam int SEGMENT_LOG2_DEF = 4;
    localparam int MAX_SPAN_DEF     = 2048;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAT_COLOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSLUCENT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RZ_SLOPE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_SCALE  = 2'd3;

    localparam logic [31:0] DEPTH_SCALE_RST = 32'h0001_0000;

    // Depth is bias minus the rounded quotient
    localparam logic [15:0] DEPTH_BIAS = 16'hFF80;
    localparam logic [23:0] BLEND_MASK = 24'hFEFEFE;

    // Dividend is depth_scale << 21: 53 bits, one quotient bit per cycle
    localparam int          DIVIDEND_SHIFT = 21;
    localparam int          DIV_CNT_W      = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_TOP_BIT = 6'd52;
    localparam logic [DIV_CNT_W-1:0] DIV_SCALE_LSB = 6'(DIVIDEND_SHIFT);
    // Only the low quotient bits survive the rounding and the mod 2^16
    localparam int          QUO_W = 17;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_DIV0,
        ST_DIV1,
        ST_DIVN,
        ST_PIX
    } t_state;

    // Round half up (drop the extra quotient bit) and subtract from the bias
    function automatic logic [15:0] depth_from_quo(input logic [QUO_W-1:0] quo);
        logic [QUO_W-1:0] rnd;
        rnd = quo + QUO_W'(1);
        return DEPTH_BIAS - rnd[QUO_W-1:1];
    endfunction

    // Half blend of two RGB888 colours, per channel, without carries across
    function automatic logic [23:0] half_blend(input logic [23:0] a, input logic [23:0] b);
        return ((a & BLEND_MASK) >> 1) + ((b & BLEND_MASK) >> 1);
    endfunction

endpackage

// ===== design/zbuffered_flat_span_fill.sv =====
// ----------------------------------------------------------------------------
// zbuffered_flat_span_fill - z-buffered flat span filler
// Per-pixel depth test and colour write with perspective-correct depth taken
// every 2^SEGMENT_LOG2 pixels by a shared bit-serial divider, linear between.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------------
//  in      | in        | i_in_valid / o_in_ready  | span_start, span_width, edge_rz,
//          |           |                          | subpixel_offset, old_depth, old_color
//  out     | out       | o_out_valid / i_out_ready| new_depth, depth_write,
//          |           |                          | new_color, color_write
//  cfg     | in        | i_cfg_valid / o_cfg_ready| cfg_index, cfg_data
//
//  Per pixel: a plain pixel takes only the depth test; a segment-boundary pixel
//  first runs one 53-step division; the first pixel of a span runs the multiply,
//  add and two divisions. The restoring divider yields one quotient bit a cycle.
//  One pixel is in flight at a time; o_in_ready is high only when idle.
//  The output register holds a result until taken; a new pixel is accepted
//  meanwhile, and its result waits in the last step if the register is full.
//  Reset is synchronous, active low; the cfg port is always ready.
// ----------------------------------------------------------------------------
module zbuffered_flat_span_fill #(
    parameter int SEGMENT_LOG2 = zbsf_pkg::SEGMENT_LOG2_DEF,
    parameter int MAX_SPAN     = zbsf_pkg::MAX_SPAN_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_span_start,
    input  logic [11:0]                      i_span_width,
    input  logic [31:0]                      i_edge_rz,
    input  logic signed [15:0]               i_subpixel_offset,
    input  logic [15:0]                      i_old_depth,
    input  logic [23:0]                      i_old_color,

    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [15:0]                      o_new_depth,
    output logic                             o_depth_write,
    output logic [23:0]                      o_new_color,
    output logic                             o_color_write,

    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [zbsf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                      i_cfg_data
);

    localparam int SEG_W = SEGMENT_LOG2 + 1;
    localparam int SL_W  = $clog2(MAX_SPAN + 1);
    localparam logic [SEG_W-1:0] SEG_LEN  = SEG_W'(1) << SEGMENT_LOG2;
    localparam logic [12:0]      MAX_W13  = 13'(MAX_SPAN);

    // Configuration
    logic [23:0]         r_flat_color,   n_flat_color;
    logic                r_translucent,  n_translucent;
    logic signed [31:0]  r_rz_slope,     n_rz_slope;
    logic [31:0]         r_depth_scale,  n_depth_scale;

    // Sequencer and span state
    zbsf_pkg::t_state    r_state,        n_state;
    logic [31:0]         r_rz_run,       n_rz_run;
    logic [15:0]         r_cur,          n_cur;
    logic [15:0]         r_step,         n_step;
    logic [15:0]         r_bnd,          n_bnd;
    logic [SEG_W-1:0]    r_seg_left,     n_seg_left;
    logic [SL_W-1:0]     r_span_left,    n_span_left;

    // Divider
    logic [zbsf_pkg::DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;
    logic [31:0]         r_rem,          n_rem;
    logic [zbsf_pkg::QUO_W-1:0] r_quo,   n_quo;
    logic signed [47:0]  r_prod,         n_prod;

    // Output register
    logic                r_out_valid,    n_out_valid;
    logic [15:0]         r_out_depth,    n_out_depth;
    logic                r_out_dw,       n_out_dw;
    logic [23:0]         r_out_color,    n_out_color;
    logic                r_out_cw,       n_out_cw;

    // Latched input pixel
    logic                r_start;
    logic [11:0]         r_width;
    logic [31:0]         r_edge;
    logic signed [15:0]  r_offset;
    logic [15:0]         r_old_depth;
    logic [23:0]         r_old_color;

    // Datapath
    logic                in_xfer;
    logic                cfg_xfer;
    logic signed [47:0]  prod;
    logic [31:0]         seg_rz_step;
    logic [zbsf_pkg::DIV_CNT_W-1:0] scale_idx;
    logic                div_bit;
    logic [32:0]         rem_sh;
    logic                rem_ge;
    logic [32:0]         rem_sub;
    logic [zbsf_pkg::QUO_W-1:0] quo_nx;
    logic [15:0]         div_depth;
    logic [15:0]         step_from;
    logic signed [16:0]  depth_diff;
    logic signed [16:0]  depth_diff_sh;
    logic [12:0]         width13;
    logic                out_free;
    logic                pass;

    assign in_xfer     = i_in_valid && o_in_ready;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;
    assign o_in_ready  = (r_state == zbsf_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;

    assign o_out_valid   = r_out_valid;
    assign o_new_depth   = r_out_depth;
    assign o_depth_write = r_out_dw;
    assign o_new_color   = r_out_color;
    assign o_color_write = r_out_cw;

    // Shared datapath pieces
    always_comb begin
        prod        = r_offset * r_rz_slope;
        seg_rz_step = r_rz_slope << SEGMENT_LOG2;

        // restoring division step: dividend bit is scale[cnt-21] or zero
        scale_idx = r_div_cnt - zbsf_pkg::DIV_SCALE_LSB;
        div_bit   = (r_div_cnt >= zbsf_pkg::DIV_SCALE_LSB) ? r_depth_scale[scale_idx[4:0]]
                                                           : 1'b0;
        rem_sh    = {r_rem, div_bit};
        rem_ge    = (rem_sh >= {1'b0, r_rz_run});
        rem_sub   = rem_sh - {1'b0, r_rz_run};
        quo_nx    = {r_quo[zbsf_pkg::QUO_W-2:0], rem_ge};
        div_depth = (r_rz_run == 32'd0) ? 16'd0 : zbsf_pkg::depth_from_quo(quo_nx);

        // segment step: arithmetic shift of the signed depth difference
        step_from     = (r_state == zbsf_pkg::ST_DIV1) ? r_cur : r_bnd;
        depth_diff    = $signed({1'b0, div_depth}) - $signed({1'b0, step_from});
        depth_diff_sh = depth_diff >>> SEGMENT_LOG2;

        width13  = {1'b0, r_width};
        out_free = !r_out_valid || i_out_ready;
        pass     = (r_cur > r_old_depth);
    end

    // Next state and sequencing
    always_comb begin
        n_state       = r_state;
        n_flat_color  = r_flat_color;
        n_translucent = r_translucent;
        n_rz_slope    = r_rz_slope;
        n_depth_scale = r_depth_scale;
        n_rz_run      = r_rz_run;
        n_cur         = r_cur;
        n_step        = r_step;
        n_bnd         = r_bnd;
        n_seg_left    = r_seg_left;
        n_span_left   = r_span_left;
        n_div_cnt     = r_div_cnt;
        n_rem         = r_rem;
        n_quo         = r_quo;
        n_prod        = r_prod;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_depth   = r_out_depth;
        n_out_dw      = r_out_dw;
        n_out_color   = r_out_color;
        n_out_cw      = r_out_cw;

        // register writes
        if (cfg_xfer) begin
            unique case (i_cfg_index)
                zbsf_pkg::CFG_FLAT_COLOR:  n_flat_color  = i_cfg_data[23:0];
                zbsf_pkg::CFG_TRANSLUCENT: n_translucent = i_cfg_data[0];
                zbsf_pkg::CFG_RZ_SLOPE:    n_rz_slope    = i_cfg_data;
                zbsf_pkg::CFG_DEPTH_SCALE: n_depth_scale = i_cfg_data;
                default: ;
            endcase
        end

        unique case (r_state)
            zbsf_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_div_cnt = zbsf_pkg::DIV_TOP_BIT;
                    n_rem     = 32'd0;
                    if (i_span_start) begin
                        n_state = zbsf_pkg::ST_MUL;
                    end else if (r_span_left != '0 && r_seg_left == '0) begin
                        n_state = zbsf_pkg::ST_DIVN;
                    end else begin
                        n_state = zbsf_pkg::ST_PIX;
                    end
                end
            end

            // offset times slope, registered before the add
            zbsf_pkg::ST_MUL: begin
                n_prod  = prod;
                n_state = zbsf_pkg::ST_ADD;
            end

            // rz at the left pixel: edge plus floor(product / 2^15)
            zbsf_pkg::ST_ADD: begin
                n_rz_run = r_edge + r_prod[46:15];
                n_state  = zbsf_pkg::ST_DIV0;
            end

            zbsf_pkg::ST_DIV0, zbsf_pkg::ST_DIV1, zbsf_pkg::ST_DIVN: begin
                n_rem     = rem_ge ? rem_sub[31:0] : rem_sh[31:0];
                n_quo     = quo_nx;
                n_div_cnt = r_div_cnt - zbsf_pkg::DIV_CNT_W'(1);
                if (r_div_cnt == '0) begin
                    n_rz_run  = r_rz_run + seg_rz_step;
                    n_div_cnt = zbsf_pkg::DIV_TOP_BIT;
                    n_rem     = 32'd0;
                    if (r_state == zbsf_pkg::ST_DIV0) begin
                        n_cur   = div_depth;
                        n_state = zbsf_pkg::ST_DIV1;
                    end else begin
                        if (r_state == zbsf_pkg::ST_DIVN) begin
                            n_cur = r_bnd;
                        end else begin
                            // span width: zero counts as one, saturate at MAX_SPAN
                            if (r_width == 12'd0) begin
                                n_span_left = SL_W'(1);
                            end else if (width13 > MAX_W13) begin
                                n_span_left = SL_W'(MAX_W13);
                            end else begin
                                n_span_left = SL_W'(width13);
                            end
                        end
                        n_bnd      = div_depth;
                        n_step     = depth_diff_sh[15:0];
                        n_seg_left = SEG_LEN;
                        n_state    = zbsf_pkg::ST_PIX;
                    end
                end
            end

            // depth test and result, once the output register is free
            zbsf_pkg::ST_PIX: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_depth = r_old_depth;
                    n_out_dw    = 1'b0;
                    n_out_color = r_old_color;
                    n_out_cw    = 1'b0;
                    if (r_span_left != '0) begin
                        if (pass) begin
                            n_out_cw = 1'b1;
                            if (r_translucent) begin
                                n_out_color = zbsf_pkg::half_blend(r_old_color, r_flat_color);
                            end else begin
                                n_out_depth = r_cur;
                                n_out_dw    = 1'b1;
                                n_out_color = r_flat_color;
                            end
                        end
                        n_cur       = r_cur + r_step;
                        n_seg_left  = r_seg_left - SEG_W'(1);
                        n_span_left = r_span_left - SL_W'(1);
                    end
                    n_state = zbsf_pkg::ST_IDLE;
                end
            end

            default: n_state = zbsf_pkg::ST_IDLE;
        endcase
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= zbsf_pkg::ST_IDLE;
            r_flat_color  <= 24'd0;
            r_translucent <= 1'b0;
            r_rz_slope    <= 32'sd0;
            r_depth_scale <= zbsf_pkg::DEPTH_SCALE_RST;
            r_rz_run      <= 32'd0;
            r_cur         <= 16'd0;
            r_step        <= 16'd0;
            r_bnd         <= 16'd0;
            r_seg_left    <= '0;
            r_span_left   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_flat_color  <= n_flat_color;
            r_translucent <= n_translucent;
            r_rz_slope    <= n_rz_slope;
            r_depth_scale <= n_depth_scale;
            r_rz_run      <= n_rz_run;
            r_cur         <= n_cur;
            r_step        <= n_step;
            r_bnd         <= n_bnd;
            r_seg_left    <= n_seg_left;
            r_span_left   <= n_span_left;
            r_out_valid   <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_div_cnt   <= n_div_cnt;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_prod      <= n_prod;
        r_out_depth <= n_out_depth;
        r_out_dw    <= n_out_dw;
        r_out_color <= n_out_color;
        r_out_cw    <= n_out_cw;
        if (in_xfer) begin
            r_start     <= i_span_start;
            r_width     <= i_span_width;
            r_edge      <= i_edge_rz;
            r_offset    <= i_subpixel_offset;
            r_old_depth <= i_old_depth;
            r_old_color <= i_old_color;
        end
    end

    // Span-start flag kept for the checks below
`ifndef ASSERT_OFF
    // a depth write always comes with a colour write
    a_dw_has_cw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_depth_write |-> o_color_write)
        else $error("depth write without colour write");

    // segment counter never exceeds one segment
    a_seg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seg_left <= SEG_LEN)
        else $error("segment counter out of range");

    // a span-start pixel always goes through the multiply
    a_start_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_span_start |=> r_state == zbsf_pkg::ST_MUL && r_start)
        else $error("span start did not enter the multiply step");

    // one pixel in flight: no transfer in the cycle after one
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !o_in_ready)
        else $error("input accepted while a pixel is in flight");
`endif

endmodule

// ===== tb/tb_zbuffered_flat_span_fill.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_zbuffered_flat_span_fill - self-checking bench for the span filler
// Streams spans of pixels into the block with random gaps on both channels.
// A local model of the segmented perspective depth, depth test and blend
// predicts every write. The checker compares each output transfer against the
// oldest prediction. Register writes happen only while the block is drained.
// ----------------------------------------------------------------------------
module tb_zbuffered_flat_span_fill;

    localparam int SEG_LOG2       = zbsf_pkg::SEGMENT_LOG2_DEF;
    localparam int SEG_PIXELS     = 1 << SEG_LOG2;
    localparam int MAX_SPAN_PIX   = zbsf_pkg::MAX_SPAN_DEF;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 150;
    localparam int SETTLE_CYCLES  = 2;
    localparam int PHASE_PIXELS   = 50;
    localparam int RANDOM_PHASES  = 4;

    typedef struct packed {
        logic [15:0] depth;
        logic        depth_wr;
        logic [23:0] color;
        logic        color_wr;
    } t_pixel_write;

    // DUT ports
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic                 i_span_start = 1'b0;
    logic [11:0]          i_span_width = '0;
    logic [31:0]          i_edge_rz = '0;
    logic signed [15:0]   i_subpixel_offset = '0;
    logic [15:0]          i_old_depth = '0;
    logic [23:0]          i_old_color = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [15:0]          o_new_depth;
    logic                 o_depth_write;
    logic [23:0]          o_new_color;
    logic                 o_color_write;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [zbsf_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data = '0;

    // Register copies
    logic [23:0] cfg_flat_color;
    logic        cfg_translucent;
    logic [31:0] cfg_rz_slope;
    logic [31:0] cfg_depth_scale;

    // Span walker copy
    logic [31:0] rz_next_boundary;
    logic [15:0] pix_depth;
    logic [15:0] pix_step;
    logic [15:0] seg_end_depth;
    int          seg_count;
    int          span_count;

    t_pixel_write pending_writes[$];

    // Sender / receiver control
    bit in_low = 1'b1;
    bit steady = 1'b0;
    bit hold_off_req = 1'b0;

    // Statistics
    int error_count = 0;
    int pixels_sent = 0;
    int spans_sent = 0;
    int results_checked = 0;
    int depth_writes = 0;
    int blend_writes = 0;
    int reg_writes = 0;
    int hold_offs = 0;
    int idle_cycles = 0;

    zbuffered_flat_span_fill #(
        .SEGMENT_LOG2 (SEG_LOG2),
        .MAX_SPAN     (MAX_SPAN_PIX)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_span_start      (i_span_start),
        .i_span_width      (i_span_width),
        .i_edge_rz         (i_edge_rz),
        .i_subpixel_offset (i_subpixel_offset),
        .i_old_depth       (i_old_depth),
        .i_old_color       (i_old_color),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_new_depth       (o_new_depth),
        .o_depth_write     (o_depth_write),
        .o_new_color       (o_new_color),
        .o_color_write     (o_color_write),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Depth model
    // ------------------------------------------------------------------

    // Bias minus round(scale * 2^20 / rz), zero for a zero reciprocal
    function automatic logic [15:0] perspective_depth(input logic [31:0] rz);
        logic [63:0] quo;
        if (rz == '0)
            return '0;
        quo = ((({32'b0, cfg_depth_scale} << 21) / {32'b0, rz}) + 64'd1) >> 1;
        return zbsf_pkg::DEPTH_BIAS - quo[15:0];
    endfunction

    // Per-pixel increment: signed difference, arithmetic shift by segment size
    function automatic logic [15:0] linear_step(input logic [15:0] from,
                                                input logic [15:0] to);
        int diff;
        diff = int'(to) - int'(from);
        return 16'(diff >>> SEG_LOG2);
    endfunction

    function automatic void predict_pixel_write(input logic        start,
                                                input logic [11:0] width,
                                                input logic [31:0] edge_rz,
                                                input logic [15:0] offset,
                                                input logic [15:0] odepth,
                                                input logic [23:0] ocolor);
        t_pixel_write w;
        longint       prod;
        longint       shifted;
        logic [31:0]  seg_rz;
        logic [31:0]  rz0;
        logic [31:0]  rz1;
        logic [15:0]  next_depth;

        seg_rz = cfg_rz_slope << SEG_LOG2;
        w.depth    = odepth;
        w.depth_wr = 1'b0;
        w.color    = ocolor;
        w.color_wr = 1'b0;

        if (start) begin
            // Edge rz corrected by the subpixel offset, floor of the product
            prod    = longint'($signed(offset)) * longint'($signed(cfg_rz_slope));
            shifted = prod >>> 15;
            rz0     = edge_rz + shifted[31:0];
            rz1     = rz0 + seg_rz;
            if (width == '0)
                span_count = 1;
            else if (width > MAX_SPAN_PIX)
                span_count = MAX_SPAN_PIX;
            else
                span_count = int'(width);
            pix_depth        = perspective_depth(rz0);
            seg_end_depth    = perspective_depth(rz1);
            rz_next_boundary = rz1 + seg_rz;
            pix_step         = linear_step(pix_depth, seg_end_depth);
            seg_count        = SEG_PIXELS;
        end else if (span_count != 0 && seg_count == 0) begin
            // Segment boundary: move on to the next sampled depth
            next_depth       = perspective_depth(rz_next_boundary);
            pix_depth        = seg_end_depth;
            seg_end_depth    = next_depth;
            rz_next_boundary = rz_next_boundary + seg_rz;
            pix_step         = linear_step(pix_depth, seg_end_depth);
            seg_count        = SEG_PIXELS;
        end

        if (span_count != 0) begin
            if (pix_depth > odepth) begin
                if (cfg_translucent) begin
                    w.color = ((ocolor & zbsf_pkg::BLEND_MASK) >> 1) +
                              ((cfg_flat_color & zbsf_pkg::BLEND_MASK) >> 1);
                end else begin
                    w.depth    = pix_depth;
                    w.depth_wr = 1'b1;
                    w.color    = cfg_flat_color;
                end
                w.color_wr = 1'b1;
            end
            pix_depth  = pix_depth + pix_step;
            seg_count  = seg_count - 1;
            span_count = span_count - 1;
        end

        if (w.depth_wr)
            depth_writes++;
        else if (w.color_wr)
            blend_writes++;
        pending_writes.push_back(w);
    endfunction

    function automatic void reset_model();
        cfg_flat_color   = '0;
        cfg_translucent  = 1'b0;
        cfg_rz_slope     = '0;
        cfg_depth_scale  = zbsf_pkg::DEPTH_SCALE_RST;
        rz_next_boundary = '0;
        pix_depth        = '0;
        pix_step         = '0;
        seg_end_depth    = '0;
        seg_count        = 0;
        span_count       = 0;
    endfunction

    // ------------------------------------------------------------------
    // Random value helpers
    // ------------------------------------------------------------------
    function automatic logic [15:0] rand_old_depth();
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_edge();
        case ($urandom_range(0, 7))
            0:       return 32'h0;
            1, 2:    return $urandom_range(1, 32'h000F_FFFF);
            3, 4:    return 32'h1000_0000 + ($urandom & 32'h0FFF_FFFF);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_slope();
        int s;
        s = $urandom;
        return s >>> $urandom_range(0, 31);
    endfunction

    function automatic logic [31:0] rand_scale();
        case ($urandom_range(0, 7))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return zbsf_pkg::DEPTH_SCALE_RST;
            3, 4:    return $urandom_range(1, 32'h000F_FFFF);
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Pixel channel
    // ------------------------------------------------------------------

    // One pixel transfer; valid stays up when the next pixel follows at once
    task automatic send_pixel(input logic        start,
                              input logic [11:0] width,
                              input logic [31:0] edge_rz,
                              input logic [15:0] offset,
                              input logic [15:0] odepth,
                              input logic [23:0] ocolor);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            if (!in_low)
                i_in_valid <= 1'b0;
            in_low = 1'b1;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_span_start      <= start;
        i_span_width      <= width;
        i_edge_rz         <= edge_rz;
        i_subpixel_offset <= offset;
        i_old_depth       <= odepth;
        i_old_color       <= ocolor;
        in_low = 1'b0;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_pixel_write(start, width, edge_rz, offset, odepth, ocolor);
        pixels_sent++;
        if (start)
            spans_sent++;
    endtask

    task automatic input_idle();
        if (!in_low)
            i_in_valid <= 1'b0;
        in_low = 1'b1;
        @(posedge i_clk);
    endtask

    task automatic start_span(input logic [11:0] width, input logic [31:0] edge_rz,
                              input logic [15:0] offset);
        send_pixel(1'b1, width, edge_rz, offset, rand_old_depth(), 24'($urandom));
    endtask

    // Follow-on pixels, with the ignored start fields randomised
    task automatic span_pixels(input int count);
        repeat (count)
            send_pixel(1'b0, 12'($urandom), $urandom, 16'($urandom),
                       rand_old_depth(), 24'($urandom));
    endtask

    task automatic wait_drained();
        input_idle();
        while (pending_writes.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Register channel: only used once the block has drained
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [zbsf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            zbsf_pkg::CFG_FLAT_COLOR:  cfg_flat_color  = data[23:0];
            zbsf_pkg::CFG_TRANSLUCENT: cfg_translucent = data[0];
            zbsf_pkg::CFG_RZ_SLOPE:    cfg_rz_slope    = data;
            zbsf_pkg::CFG_DEPTH_SCALE: cfg_depth_scale = data;
            default: ;
        endcase
        reg_writes++;
        @(posedge i_clk);
    endtask

    task automatic write_all_regs(input logic [31:0] color, input logic [31:0] mode,
                                  input logic [31:0] slope, input logic [31:0] scale);
        write_reg(zbsf_pkg::CFG_FLAT_COLOR, color);
        write_reg(zbsf_pkg::CFG_TRANSLUCENT, mode);
        write_reg(zbsf_pkg::CFG_RZ_SLOPE, slope);
        write_reg(zbsf_pkg::CFG_DEPTH_SCALE, scale);
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < 100)
            $display("mismatch: %s at result %0d: got %h, expected %h",
                     what, results_checked, got, want);
        error_count++;
    endtask

    initial begin : result_checker
        int           stall;
        t_pixel_write want;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                stall = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
                hold_offs++;
            end else begin
                stall = steady ? 0 : $urandom_range(0, 3);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            if (pending_writes.size() == 0) begin
                report_mismatch("unexpected result", {8'b0, o_new_color}, 32'd0);
            end else begin
                want = pending_writes.pop_front();
                if (o_new_depth !== want.depth)
                    report_mismatch("new_depth", 32'(o_new_depth), 32'(want.depth));
                if (o_depth_write !== want.depth_wr)
                    report_mismatch("depth_write", 32'(o_depth_write),
                                    32'(want.depth_wr));
                if (o_new_color !== want.color)
                    report_mismatch("new_color", 32'(o_new_color), 32'(want.color));
                if (o_color_write !== want.color_wr)
                    report_mismatch("color_write", 32'(o_color_write),
                                    32'(want.color_wr));
            end
            results_checked++;
        end
    end

    // Watchdog: cycles with no transfer on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, pending_writes.size());
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Defaults after reset: idle pixels, zero reciprocal, single-pixel span
    task automatic test_reset_state();
        send_pixel(1'b0, 12'd5, 32'h1000_0000, 16'h0, 16'h0000, 24'h123456);
        send_pixel(1'b1, 12'd1, 32'h0, 16'h0, 16'h0000, 24'h654321);
        send_pixel(1'b1, 12'd1, 32'h1000_0000, 16'h0, 16'h0000, 24'hABCDEF);
        send_pixel(1'b0, 12'd0, 32'h0, 16'h0, 16'hFFFF, 24'hFFFFFF);
    endtask

    // Field and register extremes, width zero and above the limit, restart
    task automatic test_field_extremes();
        write_all_regs(32'hFFFF_FFFF, 32'h1, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_pixel(1'b1, 12'd0, 32'hFFFF_FFFF, 16'h7FFF, 16'h0000, 24'h000000);
        send_pixel(1'b1, 12'hFFF, 32'h8000_0000, 16'h8000, 16'h0000, 24'hFFFFFF);
        send_pixel(1'b0, 12'd0, 32'h0, 16'h0, 16'h0000, 24'h808080);
        // new span before the running one ends
        send_pixel(1'b1, 12'd2, 32'h0000_0001, 16'h8000, 16'h0000, 24'h010101);
        send_pixel(1'b0, 12'hFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 24'hFEFEFE);
        write_all_regs(32'h0000_0000, 32'h0, 32'h8000_0000, 32'h0);
        send_pixel(1'b1, 12'd2, 32'h1234_5678, 16'h8000, 16'h0000, 24'hFFFFFF);
        send_pixel(1'b0, 12'd0, 32'h0, 16'h7FFF, 16'h0000, 24'h000000);
    endtask

    // Boundary evaluation, a one-pixel last segment and round-half-up quotient
    task automatic test_segment_rounding();
        write_all_regs(32'h00C0_FFEE, 32'h0, 32'h0000_1000, 32'h1);
        send_pixel(1'b1, 12'd17, 32'h0020_0000, 16'h0, 16'h0000, 24'h0);
        repeat (SEG_PIXELS)
            send_pixel(1'b0, 12'd0, 32'h0, 16'h0, 16'($urandom), 24'($urandom));
    endtask

    // Registers rewritten part way through a span
    task automatic test_config_mid_span();
        write_all_regs(32'h0033_66CC, 32'h0, 32'h0010_0000, zbsf_pkg::DEPTH_SCALE_RST);
        start_span(12'd48, 32'h1000_0000, 16'($urandom));
        span_pixels(19);
        write_all_regs(32'h00CC_6633, 32'h1, 32'hFFF0_0000, 32'h0002_0000);
        span_pixels(28);
    endtask

    // Receiver holds off while the sender keeps offering pixels
    task automatic test_output_hold_off();
        write_all_regs($urandom, $urandom, rand_slope(), rand_scale());
        hold_off_req = 1'b1;
        start_span(12'd40, rand_edge(), 16'($urandom));
        span_pixels(39);
    endtask

    // Sender stops mid-span until every result has come back
    task automatic test_input_pause();
        start_span(12'd50, rand_edge(), 16'($urandom));
        span_pixels(19);
        wait_drained();
        span_pixels(30);
    endtask

    // Oversized width clipped to the span limit, run through to its end
    task automatic test_span_saturation();
        write_all_regs($urandom, 32'h0, 32'h0000_8000, zbsf_pkg::DEPTH_SCALE_RST);
        start_span(12'hFFF, 32'h0800_0000, 16'($urandom));
        span_pixels(MAX_SPAN_PIX + 1);
    endtask

    // Mostly complete spans, some cut short, some with idle pixels after
    task automatic random_span();
        logic [11:0] width;
        int          eff;
        int          pixels;
        case ($urandom_range(0, 19))
            0:       width = 12'd0;
            1:       width = 12'($urandom_range(100, 300));
            2:       width = 12'($urandom_range(MAX_SPAN_PIX + 1, 4095));
            default: width = 12'($urandom_range(1, 40));
        endcase
        if (width == 0)
            eff = 1;
        else if (width > MAX_SPAN_PIX)
            eff = $urandom_range(1, 24);
        else
            eff = int'(width);
        case ($urandom_range(0, 9))
            0:       pixels = $urandom_range(1, eff);
            1:       pixels = eff + $urandom_range(1, 3);
            default: pixels = eff;
        endcase
        start_span(width, rand_edge(), 16'($urandom));
        span_pixels(pixels - 1);
    endtask

    task automatic test_random_spans();
        int first;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_all_regs($urandom, $urandom, rand_slope(), rand_scale());
            wait_drained();
            // every fourth phase runs with no gaps on either side
            steady = (phase % 4 == 1);
            first = pixels_sent;
            while (pixels_sent - first < PHASE_PIXELS)
                random_span();
            wait_drained();
            steady = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        reset_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_field_extremes();
        test_segment_rounding();
        test_config_mid_span();
        test_output_hold_off();
        test_input_pause();
        test_span_saturation();
        test_random_spans();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d pixels in %0d spans, %0d register writes, %0d output hold-offs",
                 pixels_sent, spans_sent, reg_writes, hold_offs);
        $display("Checked %0d results: %0d depth writes, %0d blended colour writes, %0d errors",
                 results_checked, depth_writes, blend_writes, error_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
